// ===== src/stt_pkg.sv =====
// Package for the section timer table: types, state codes and register indexes.
// No dependencies; imported by every module of the block.
`default_nettype none
package stt_pkg;
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_UPDATE,
        ST_MOD,
        ST_MUL_TC,
        ST_MUL_LHS,
        ST_MUL_RHS,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        REG_SHUTOFF_ENABLE = 3'd0,
        REG_CHECK_PERIOD   = 3'd1,
        REG_THRESHOLD_US   = 3'd2,
        REG_CLOCK_HZ       = 3'd3,
        REG_TRACK_UNENTERED = 3'd4
    } reg_index_t;

    typedef enum logic [1:0] {
        STATUS_COUNTED   = 2'd0,
        STATUS_UNENTERED = 2'd1,
        STATUS_IGNORED   = 2'd2
    } status_t;

    localparam int unsigned USEC_PER_SEC = 1000000;
    localparam int unsigned PROD_W = 160;
    localparam int unsigned CFG_W = 40;
endpackage
`default_nettype wire

// ===== src/section_timer_table.sv =====
// Section timer table top level: per-section state memory, update sequencer,
// bit-serial modulo and bit-serial products. Depends on stt_pkg.
//
// One event word is taken at a time. Each word passes through the read and update
// states to the result state and then back to idle. An exit that runs the average
// check also runs the modulo, and when the visit count is a multiple of check period
// it then runs the products: the modulo is done one bit per cycle, then threshold
// times clock is formed one multiplier bit per cycle, then the two products are
// formed by shift-and-add one multiplier bit per cycle (run back to back). A stalled
// result adds its wait. After reset the state memory is cleared one section per
// cycle, and no event word is taken until the clearing is done.
`default_nettype none
module section_timer_table #(
    parameter int SECTIONS = 256
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // tdata: timestamp[63:0]
    input  wire logic [63:0]  s_tdata,
    // tuser: operation[0], section[8:1]
    input  wire logic [8:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // tdata: section_out[7:0], depth[23:8], visits[87:24], accum_cycles[151:88],
    //        event_status[153:152], newly_off[154], zero padding above
    output logic [159:0]      m_tdata,
    input  wire logic         cfg_we,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [39:0]  cfg_data
);
    import stt_pkg::*;

    localparam int AW = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;

    // Configuration registers.
    logic        shutoff_enable_reg;
    logic [31:0] check_period_reg;
    logic [31:0] threshold_us_reg;
    logic [39:0] clock_hz_reg;
    logic        track_unentered_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shutoff_enable_reg  <= 1'b0;
            check_period_reg    <= 32'd100;
            threshold_us_reg    <= 32'd5000;
            clock_hz_reg        <= 40'd3200000000;
            track_unentered_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (reg_index_t'(cfg_index))
                REG_SHUTOFF_ENABLE:  shutoff_enable_reg  <= cfg_data[0];
                REG_CHECK_PERIOD:    check_period_reg    <= cfg_data[31:0];
                REG_THRESHOLD_US:    threshold_us_reg    <= cfg_data[31:0];
                REG_CLOCK_HZ:        clock_hz_reg        <= cfg_data;
                REG_TRACK_UNENTERED: track_unentered_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Per-section state memory, one wide row per section.
    localparam int ROW_W = 16 + 64 + 64 + 64 + 1 + 32;
    logic [ROW_W-1:0] mem [SECTIONS];
    logic [ROW_W-1:0] rd_row_reg;
    logic             mem_we;
    logic [AW-1:0]    mem_addr;
    logic [ROW_W-1:0] mem_wdata;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_wdata;
        rd_row_reg <= mem[mem_addr];
    end

    // Sequencer and working registers.
    state_t       state_reg, state_next;
    logic [AW:0]  clr_cnt_reg;
    logic         clearing;
    logic         op_reg;
    logic [7:0]   sec_reg;
    logic [63:0]  ts_reg;
    logic         in_range;
    logic [15:0]  dep_reg;
    logic [63:0]  vis_reg, last_reg, acc_reg;
    logic         off_reg;
    logic [31:0]  unent_reg;
    logic [1:0]   status_reg;
    logic         newly_reg;
    logic         do_check_reg;
    logic [6:0]   bit_cnt_reg;
    logic [31:0]  rem_reg;
    logic [63:0]  shf_reg;
    logic [PROD_W-1:0] lhs_reg, rhs_reg, madd_reg;
    logic [71:0]  tc_reg;

    assign clearing = (clr_cnt_reg < (AW+1)'(SECTIONS));
    assign in_range = ({24'd0, sec_reg} < 32'(SECTIONS));

    // Remainder step of the serial modulo.
    logic [32:0] rem_shift;
    logic [32:0] rem_sub;
    assign rem_shift = {rem_reg, shf_reg[63]};
    assign rem_sub   = rem_shift - {1'b0, check_period_reg};

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:    if (s_tvalid && s_tready) state_next = ST_READ;
            ST_READ:    state_next = ST_UPDATE;
            ST_UPDATE:  state_next = do_check_reg ? ST_MOD : ST_DONE;
            ST_MOD:     if (bit_cnt_reg == 7'd63)
                            state_next = (rem_shift == 33'd0 || rem_sub == 33'd0) ?
                                ST_MUL_TC : ST_DONE;
            ST_MUL_TC:  if (bit_cnt_reg == 7'd31) state_next = ST_MUL_LHS;
            ST_MUL_LHS: if (bit_cnt_reg == 7'd63) state_next = ST_MUL_RHS;
            ST_MUL_RHS: if (bit_cnt_reg == 7'd63) state_next = ST_DONE;
            ST_DONE:    if (m_tready) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // Handshake outputs.
    always_comb
    begin
        s_tready = (state_reg == ST_IDLE) && !clearing;
        m_tvalid = (state_reg == ST_DONE);
    end

    // Memory port: clearing sweep, read of the addressed row, write back.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_addr  = sec_reg[AW-1:0];
        mem_wdata = {dep_reg, vis_reg, last_reg, acc_reg, off_reg, unent_reg};
        if (clearing)
        begin
            mem_we    = 1'b1;
            mem_addr  = clr_cnt_reg[AW-1:0];
            mem_wdata = '0;
        end
        else if (state_reg == ST_IDLE)
            mem_addr = s_tuser[AW:1];
        else if (state_reg == ST_DONE && m_tready && in_range)
            mem_we = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (clearing)
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    // Fields of the row just read.
    logic [15:0] row_dep;
    logic [63:0] row_vis, row_last, row_acc;
    logic        row_off;
    logic [31:0] row_unent;
    assign {row_dep, row_vis, row_last, row_acc, row_off, row_unent} = rd_row_reg;

    // Event update of the row read for the current word.
    logic [15:0] upd_dep;
    logic [63:0] upd_vis, upd_last, upd_acc;
    logic        upd_off;
    logic [31:0] upd_unent;
    status_t     upd_status;
    logic        upd_newly;
    logic        upd_check;

    always_comb
    begin
        upd_dep    = row_dep;
        upd_vis    = row_vis;
        upd_last   = row_last;
        upd_acc    = row_acc;
        upd_off    = row_off;
        upd_unent  = row_unent;
        upd_status = STATUS_COUNTED;
        upd_newly  = 1'b0;
        upd_check  = 1'b0;
        if (!in_range || row_off)
            upd_status = STATUS_IGNORED;
        else if (!op_reg)
        begin
            if (row_dep == 16'd0)
            begin
                upd_vis  = row_vis + 64'd1;
                upd_last = ts_reg;
            end
            if (row_dep != 16'hFFFF)
                upd_dep = row_dep + 16'd1;
        end
        else if (row_dep == 16'd0)
        begin
            upd_status = STATUS_UNENTERED;
            if (row_unent != 32'hFFFFFFFF)
                upd_unent = row_unent + 32'd1;
            if (!track_unentered_reg)
            begin
                upd_off   = 1'b1;
                upd_newly = 1'b1;
            end
        end
        else
        begin
            upd_dep = row_dep - 16'd1;
            if (row_dep == 16'd1)
            begin
                upd_acc  = row_acc + ts_reg - row_last;
                upd_last = ts_reg;
            end
            upd_check = shutoff_enable_reg && (check_period_reg != 32'd0) &&
                        (row_vis != 64'd0);
        end
    end

    // Datapath.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                op_reg  <= s_tuser[0];
                sec_reg <= s_tuser[8:1];
                ts_reg  <= s_tdata;
            end
            ST_READ:
            begin
                dep_reg      <= upd_dep;
                vis_reg      <= upd_vis;
                last_reg     <= upd_last;
                acc_reg      <= upd_acc;
                off_reg      <= upd_off;
                unent_reg    <= upd_unent;
                status_reg   <= upd_status;
                newly_reg    <= upd_newly;
                do_check_reg <= upd_check;
            end
            ST_UPDATE:
            begin
                bit_cnt_reg <= 7'd0;
                rem_reg     <= 32'd0;
                shf_reg     <= vis_reg;
            end
            ST_MOD:
            begin
                rem_reg <= rem_sub[32] ? rem_shift[31:0] : rem_sub[31:0];
                if (bit_cnt_reg == 7'd63)
                begin
                    bit_cnt_reg <= 7'd0;
                    shf_reg     <= {32'd0, threshold_us_reg};
                    madd_reg    <= PROD_W'(clock_hz_reg);
                    tc_reg      <= '0;
                end
                else
                begin
                    shf_reg     <= {shf_reg[62:0], 1'b0};
                    bit_cnt_reg <= bit_cnt_reg + 7'd1;
                end
            end
            ST_MUL_TC:
            begin
                // Threshold times clock, one threshold bit per cycle.
                if (shf_reg[0])
                    tc_reg <= tc_reg + madd_reg[71:0];
                if (bit_cnt_reg == 7'd31)
                begin
                    bit_cnt_reg <= 7'd0;
                    shf_reg     <= acc_reg;
                    madd_reg    <= PROD_W'(USEC_PER_SEC);
                    lhs_reg     <= '0;
                end
                else
                begin
                    madd_reg    <= {madd_reg[PROD_W-2:0], 1'b0};
                    shf_reg     <= {1'b0, shf_reg[63:1]};
                    bit_cnt_reg <= bit_cnt_reg + 7'd1;
                end
            end
            ST_MUL_LHS:
            begin
                // Accumulator times one million, one multiplier bit per cycle.
                if (shf_reg[0])
                    lhs_reg <= lhs_reg + madd_reg;
                if (bit_cnt_reg == 7'd63)
                begin
                    bit_cnt_reg <= 7'd0;
                    shf_reg     <= vis_reg;
                    madd_reg    <= PROD_W'(tc_reg);
                    rhs_reg     <= '0;
                end
                else
                begin
                    madd_reg    <= {madd_reg[PROD_W-2:0], 1'b0};
                    shf_reg     <= {1'b0, shf_reg[63:1]};
                    bit_cnt_reg <= bit_cnt_reg + 7'd1;
                end
            end
            ST_MUL_RHS:
            begin
                // Threshold-clock product times visits; the last bit feeds the compare.
                if (bit_cnt_reg == 7'd63)
                begin
                    if (lhs_reg < (shf_reg[0] ? rhs_reg + madd_reg : rhs_reg))
                    begin
                        off_reg   <= 1'b1;
                        newly_reg <= 1'b1;
                    end
                end
                else
                begin
                    if (shf_reg[0])
                        rhs_reg <= rhs_reg + madd_reg;
                    madd_reg    <= {madd_reg[PROD_W-2:0], 1'b0};
                    shf_reg     <= {1'b0, shf_reg[63:1]};
                    bit_cnt_reg <= bit_cnt_reg + 7'd1;
                end
            end
            default: ;
        endcase
    end

    // Result word.
    always_comb
    begin
        m_tdata = '0;
        m_tdata[7:0] = sec_reg;
        if (in_range)
        begin
            m_tdata[23:8]    = dep_reg;
            m_tdata[87:24]   = vis_reg;
            m_tdata[151:88]  = acc_reg;
            m_tdata[154]     = newly_reg;
        end
        m_tdata[153:152] = status_reg;
    end

`ifndef SYNTHESIS
    a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !s_tready) else $error("word taken during clear");
    a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready) else $error("input ready while result pending");
    a_read_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> state_reg == ST_READ) else $error("no read");
`endif
endmodule
`default_nettype wire
